/* rtl/core/circular_deque_unit_defines.svh */
// Assertion macros for the circular deque RTL.
// Taken in by the top level with `include; no other dependencies.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define CDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("circular deque assertion failed");
// next-cycle implication
`define CDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("circular deque assertion failed");
`else
`define CDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/cdq_pkg.sv */
// Shared types and constants for the circular deque.
// No dependencies; used by every module of the block.
package cdq_pkg;

	localparam int DEPTH      = 8;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int DATA_W     = 32;
	localparam int ITEM_CNT_W = 4;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [DATA_W-1:0] word_t;

	// broadcast to every cell; count is the count before the update
	typedef struct packed {
		logic   load_front;
		logic   load_back;
		logic   shift_left;
		count_t count;
	} cell_cmd_t;

endpackage

/* rtl/core/circular_deque_unit.sv */
// Circular deque unit: top level, a row of cdq_cell slots steered by cdq_ctrl.
// Depends on cdq_pkg, cdq_cell, cdq_ctrl and circular_deque_unit_defines.svh.
//
// Usage:
//   Slave channel (s_*): one request per transfer. s_tuser carries the
//   operation (push front, push back, pop front, pop back), s_tdata the word
//   to push, ignored on pops.
//   Master channel (m_*): one response per request with the status, the item
//   count after the request and the front and back words (zero when empty).
//   A push into a full deque or a pop from an empty one changes nothing and
//   answers with a full or empty status.
//   Latency: the response is valid the cycle after the request is taken.
//   Throughput: one request per cycle while m_tready is high; the response
//   comes straight off the slot registers, which shift or load on accept.
//   Reset: the deque comes up empty and no response is pending.
//   Stall: while a response waits on m_tready, s_tready stays low, the slot
//   row holds, and the response stays stable; a request is taken in the same
//   cycle that the waiting response leaves.
`include "circular_deque_unit_defines.svh"

module circular_deque_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] data
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [1:0] status, [5:2] item_count,
	                               // [37:6] head_value, [69:38] tail_value, rest zero
);
	import cdq_pkg::*;

	logic      s_accept;
	logic      m_tvalid_q;
	cell_cmd_t cmd;
	status_t   status;
	word_t     cell_value [DEPTH];
	word_t     cell_tail  [DEPTH];
	word_t     head_value;
	word_t     tail_value;
	logic      push_req;
	logic      full_now;
	logic      empty_now;

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (s_accept),
		.op     (op_t'(s_tuser)),
		.cmd    (cmd),
		.status (status)
	);

	// slot row: slot 0 is the front
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (gi == 0) begin : g_first
			assign left_w = s_tdata;
		end else begin : g_mid
			assign left_w = cell_value[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = cell_value[gi+1];
		end
		cdq_cell u_cell (
			.clk        (clk),
			.idx        (count_t'(gi)),
			.cmd        (cmd),
			.left_in    (left_w),
			.right_in   (right_w),
			.push_data  (s_tdata),
			.value      (cell_value[gi]),
			.tail_value (cell_tail[gi])
		);
	end

	// tail bus: at most one slot drives nonzero
	always_comb begin
		tail_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_value = tail_value | cell_tail[i];
		end
	end

	assign head_value = (cmd.count == '0) ? '0 : cell_value[0];

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, tail_value, head_value,
	                   ITEM_CNT_W'(cmd.count), status};

	// terms for the checks
	assign push_req  = s_accept && ((s_tuser == OP_PUSH_FRONT) || (s_tuser == OP_PUSH_BACK));
	assign full_now  = (cmd.count == count_t'(DEPTH));
	assign empty_now = (cmd.count == '0);

	// checks
	`CDQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, cmd.count <= count_t'(DEPTH))
	`CDQ_ASSERT_NXT(a_full_push, clk, arst_n, push_req && full_now, (status == ST_FULL) && $stable(cmd.count))
	`CDQ_ASSERT_IMP(a_empty_zero, clk, arst_n, m_tvalid_q && empty_now, (head_value | tail_value) == '0)
	`CDQ_ASSERT_IMP(a_ready_stall, clk, arst_n, !s_tready, m_tvalid_q && !m_tready)

endmodule

/* rtl/core/cdq_cell.sv */
// One slot of the deque row: holds a word and trades it with its neighbors.
// Depends on cdq_pkg.
module cdq_cell (
	input  logic              clk,
	input  cdq_pkg::count_t   idx,
	input  cdq_pkg::cell_cmd_t cmd,
	input  cdq_pkg::word_t    left_in,
	input  cdq_pkg::word_t    right_in,
	input  cdq_pkg::word_t    push_data,
	output cdq_pkg::word_t    value,
	output cdq_pkg::word_t    tail_value
);
	import cdq_pkg::*;

	word_t value_q;

	// push front shifts toward the back, pop front toward the front
	always_ff @(posedge clk) begin
		if (cmd.load_front) begin
			value_q <= left_in;
		end else if (cmd.shift_left) begin
			value_q <= right_in;
		end else if (cmd.load_back && (idx == cmd.count)) begin
			value_q <= push_data;
		end
	end

	assign value = value_q;

	// only the back-most occupied cell contributes to the tail bus
	assign tail_value = ((idx + count_t'(1)) == cmd.count) ? value_q : '0;

endmodule

/* rtl/core/cdq_ctrl.sv */
// Request decode, item count and status for the circular deque.
// Depends on cdq_pkg.
module cdq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  cdq_pkg::op_t       op,
	output cdq_pkg::cell_cmd_t cmd,
	output cdq_pkg::status_t   status
);
	import cdq_pkg::*;

	count_t  count_q;
	status_t status_q;
	logic    full;
	logic    empty;
	logic    inc;
	logic    dec;
	status_t status_d;

	assign full  = (count_q == count_t'(DEPTH));
	assign empty = (count_q == '0);

	// decode one request into cell commands
	always_comb begin
		cmd            = '0;
		cmd.count      = count_q;
		inc            = 1'b0;
		dec            = 1'b0;
		status_d       = ST_DONE;
		unique case (op)
			OP_PUSH_FRONT: begin
				cmd.load_front = accept && !full;
				inc            = accept && !full;
				if (full) status_d = ST_FULL;
			end
			OP_PUSH_BACK: begin
				cmd.load_back = accept && !full;
				inc           = accept && !full;
				if (full) status_d = ST_FULL;
			end
			OP_POP_FRONT: begin
				cmd.shift_left = accept && !empty;
				dec            = accept && !empty;
				if (empty) status_d = ST_EMPTY;
			end
			OP_POP_BACK: begin
				dec = accept && !empty;
				if (empty) status_d = ST_EMPTY;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	// count and status of the last request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ST_DONE;
		end else if (accept) begin
			status_q <= status_d;
			if (inc) begin
				count_q <= count_q + count_t'(1);
			end else if (dec) begin
				count_q <= count_q - count_t'(1);
			end
		end
	end

	assign status = status_q;

endmodule
